FILE: sv/cau_pkg.sv
// cau_pkg: shared constants, types and the saturating clip for the complex unit.
// No dependencies.
package cau_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int SUM_W     = 2 * WORD_BITS + 2;   // product sums, signed
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  typedef struct packed {
    logic [1:0]                  op;
    logic                        dz;    // divide with zero divisor
    logic signed [WORD_BITS-1:0] a_re;
    logic signed [WORD_BITS-1:0] a_im;
    logic signed [WORD_BITS-1:0] b_re;
    logic signed [WORD_BITS-1:0] b_im;
  } item_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] re;
    logic [WORD_BITS-1:0] im;
    logic                 dz;
    logic                 sat;
  } result_t;

  // {clipped flag, word}
  function automatic logic [WORD_BITS:0] clip_word(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    logic [WORD_BITS:0]      r;
    hi = SUM_W'({1'b0, {(WORD_BITS-1){1'b1}}});
    lo = -hi - SUM_W'(1);
    if (v > hi)      r = {1'b1, 1'b0, {(WORD_BITS-1){1'b1}}};
    else if (v < lo) r = {1'b1, 1'b1, {(WORD_BITS-1){1'b0}}};
    else             r = {1'b0, v[WORD_BITS-1:0]};
    return r;
  endfunction

endpackage

FILE: sv/cau_front.sv
// cau_front: takes request words and classifies them for the queue.
// Depends on cau_pkg.
module cau_front import cau_pkg::*; (
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  req_type,
  input  logic signed [WORD_BITS-1:0] a_re,
  input  logic signed [WORD_BITS-1:0] a_im,
  input  logic signed [WORD_BITS-1:0] b_re,
  input  logic signed [WORD_BITS-1:0] b_im,
  input  logic                        q_full,
  output logic                        push,
  output item_t                       item
);

  assign busy = q_full;
  assign push = start && !q_full;

  always_comb begin
    item.op   = req_type;
    item.dz   = (req_type == OP_DIV) && (b_re == '0) && (b_im == '0);
    item.a_re = a_re;
    item.a_im = a_im;
    item.b_re = b_re;
    item.b_im = b_im;
  end

endmodule

FILE: sv/cau_queue.sv
// cau_queue: short FIFO of classified words between front and back.
// Depends on cau_pkg.
module cau_queue import cau_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t wr_item,
  input  logic  pop,
  output item_t rd_item,
  output logic  not_empty,
  output logic  full
);

  item_t              mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_PTR_W:0]   count;
  logic               do_pop;

  assign not_empty = (count != '0);
  assign full      = (count == (Q_PTR_W+1)'(Q_DEPTH));
  assign do_pop    = pop && not_empty;
  assign rd_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push)   wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(do_pop);
    end
  end

endmodule

FILE: sv/cau_back.sv
// cau_back: multiply and sum pipeline, rounding, saturation and a bit-serial divider.
// Depends on cau_pkg.
module cau_back import cau_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  item_t   q_item,
  input  logic    q_not_empty,
  output logic    pop,
  output logic    done,
  output result_t res
);

  localparam int MAG_W = 2 * WORD_BITS;
  localparam int N_W   = 2 * WORD_BITS + FRAC_BITS + 2;
  localparam int D_W   = 2 * WORD_BITS + 1;
  localparam int R_W   = D_W + 1;
  localparam int CNT_W = $clog2(WORD_BITS + 3);
  localparam int IDX_W = $clog2(WORD_BITS);
  localparam logic [CNT_W-1:0] CNT_OVF = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_FIN = CNT_W'(WORD_BITS + 2);

  logic adv;
  logic div_busy;

  // stage 1: products, and the add / subtract results
  logic                          s1_v;
  logic [1:0]                    s1_op;
  logic                          s1_dz;
  logic signed [2*WORD_BITS-1:0] p_rr, p_ii, p_ri, p_ir, p_bb_r, p_bb_i;
  logic signed [WORD_BITS:0]     s1_re, s1_im;

  // stage 2: sums
  logic                    s2_v;
  logic [1:0]              s2_op;
  logic                    s2_dz;
  logic signed [SUM_W-1:0] sum_re, sum_im;
  logic [MAG_W-1:0]        s2_d;

  // divider, two lanes
  logic [CNT_W-1:0] cnt;
  logic [MAG_W-1:0] dd;
  logic [MAG_W-1:0] mag [2];
  logic             ng  [2];
  logic [N_W-1:0]   nn  [2];
  logic [R_W-1:0]   rr  [2];
  logic [WORD_BITS-1:0] qq [2];
  logic             ovf [2];

  logic [IDX_W-1:0] idx;
  logic [D_W-1:0]   dv;

  assign adv = !div_busy;
  assign pop = adv && q_not_empty;
  assign dv  = {dd, 1'b0};
  assign idx = IDX_W'(CNT_FIN - CNT_W'(1) - cnt);

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op  <= q_item.op;
      s1_dz  <= q_item.dz;
      p_rr   <= q_item.a_re * q_item.b_re;
      p_ii   <= q_item.a_im * q_item.b_im;
      p_ri   <= q_item.a_re * q_item.b_im;
      p_ir   <= q_item.a_im * q_item.b_re;
      p_bb_r <= q_item.b_re * q_item.b_re;
      p_bb_i <= q_item.b_im * q_item.b_im;
      if (q_item.op == OP_SUB) begin
        s1_re <= (WORD_BITS+1)'(q_item.a_re) - (WORD_BITS+1)'(q_item.b_re);
        s1_im <= (WORD_BITS+1)'(q_item.a_im) - (WORD_BITS+1)'(q_item.b_im);
      end else begin
        s1_re <= (WORD_BITS+1)'(q_item.a_re) + (WORD_BITS+1)'(q_item.b_re);
        s1_im <= (WORD_BITS+1)'(q_item.a_im) + (WORD_BITS+1)'(q_item.b_im);
      end

      s2_op <= s1_op;
      s2_dz <= s1_dz;
      s2_d  <= MAG_W'($unsigned(p_bb_r)) + MAG_W'($unsigned(p_bb_i));
      case (s1_op)
        OP_MUL: begin
          sum_re <= SUM_W'(p_rr) - SUM_W'(p_ii);
          sum_im <= SUM_W'(p_ri) + SUM_W'(p_ir);
        end
        OP_DIV: begin
          sum_re <= SUM_W'(p_rr) + SUM_W'(p_ii);
          sum_im <= SUM_W'(p_ir) - SUM_W'(p_ri);
        end
        default: begin
          sum_re <= SUM_W'(s1_re);
          sum_im <= SUM_W'(s1_im);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else if (adv) begin
      s1_v <= q_not_empty;
      s2_v <= s1_v;
    end
  end

  // divider sequencing: setup, overflow check, one quotient bit a cycle, finish
  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      cnt      <= '0;
    end else if (div_busy) begin
      if (cnt == CNT_FIN) div_busy <= 1'b0;
      cnt <= cnt + CNT_W'(1);
    end else if (s2_v && s2_op == OP_DIV && !s2_dz) begin
      div_busy <= 1'b1;
      cnt      <= '0;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [SUM_W-1:0] sv;
    logic [R_W-1:0]          t;
    for (int l = 0; l < 2; l++) begin
      if (!div_busy) begin
        sv     = (l == 0) ? sum_re : sum_im;
        ng[l]  <= sv[SUM_W-1];
        mag[l] <= sv[SUM_W-1] ? MAG_W'(-sv) : MAG_W'(sv);
        qq[l]  <= '0;
      end else if (cnt == '0) begin
        nn[l] <= N_W'({mag[l], {(FRAC_BITS+1){1'b0}}}) + N_W'(dd);
      end else if (cnt == CNT_OVF) begin
        ovf[l] <= (nn[l][N_W-1:WORD_BITS] >= N_W'(dv));
        rr[l]  <= R_W'(nn[l][N_W-1:WORD_BITS]);
      end else if (cnt != CNT_FIN) begin
        t = {rr[l][R_W-2:0], nn[l][idx]};
        if (t >= R_W'(dv)) begin
          rr[l] <= t - R_W'(dv);
          qq[l] <= {qq[l][WORD_BITS-2:0], 1'b1};
        end else begin
          rr[l] <= t;
          qq[l] <= {qq[l][WORD_BITS-2:0], 1'b0};
        end
      end
    end
    if (!div_busy) dd <= s2_d;
  end

  // output word
  logic [WORD_BITS:0] cl_re, cl_im;
  logic [WORD_BITS:0] dl  [2];

  always_comb begin
    logic signed [SUM_W-1:0] half;
    half = (FRAC_BITS > 0) ? SUM_W'(1) <<< (FRAC_BITS - 1) : '0;
    if (s2_op == OP_MUL) begin
      cl_re = clip_word((sum_re + half) >>> FRAC_BITS);
      cl_im = clip_word((sum_im + half) >>> FRAC_BITS);
    end else begin
      cl_re = clip_word(sum_re);
      cl_im = clip_word(sum_im);
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (ovf[l]) begin
        dl[l] = ng[l] ? {1'b1, 1'b1, {(WORD_BITS-1){1'b0}}}
                      : {1'b1, 1'b0, {(WORD_BITS-1){1'b1}}};
      end else if (ng[l]) begin
        if (qq[l] > {1'b1, {(WORD_BITS-1){1'b0}}})
          dl[l] = {1'b1, 1'b1, {(WORD_BITS-1){1'b0}}};
        else
          dl[l] = {1'b0, -qq[l]};
      end else if (qq[l][WORD_BITS-1]) begin
        dl[l] = {1'b1, 1'b0, {(WORD_BITS-1){1'b1}}};
      end else begin
        dl[l] = {1'b0, qq[l]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (div_busy && cnt == CNT_FIN) ||
              (adv && s2_v && (s2_op != OP_DIV || s2_dz));
    end
  end

  always_ff @(posedge clk) begin
    if (div_busy) begin
      res.re  <= dl[0][WORD_BITS-1:0];
      res.im  <= dl[1][WORD_BITS-1:0];
      res.dz  <= 1'b0;
      res.sat <= dl[0][WORD_BITS] | dl[1][WORD_BITS];
    end else if (s2_op == OP_DIV) begin
      res.re  <= '0;
      res.im  <= '0;
      res.dz  <= 1'b1;
      res.sat <= 1'b0;
    end else begin
      res.re  <= cl_re[WORD_BITS-1:0];
      res.im  <= cl_im[WORD_BITS-1:0];
      res.dz  <= 1'b0;
      res.sat <= cl_re[WORD_BITS] | cl_im[WORD_BITS];
    end
  end

endmodule

FILE: sv/complex_arith_unit.sv
// complex_arith_unit: top level of the complex add / subtract / multiply / divide unit.
// Depends on cau_pkg, cau_front, cau_queue and cau_back.
//
// Usage
//   Request: drive req_type and the four Q16.16 operand parts with start high;
//   the word is taken at the rising edge where start is high and busy is low.
//   Result: done is high for exactly one cycle with res_re, res_im, div_zero
//   and saturated valid; there is no back-pressure, the receiver must take it.
//   Results leave in request order, one per request.
// Pipeline and throughput
//   Add, subtract, multiply, divide-by-zero: a word passes the queue, product,
//   sum and output registers; 1 word/cycle while no divide holds the back end.
//   Divide: after product and sum, the word runs the shared radix-2 divider (setup,
//   overflow check, 32 quotient bits, finish) before the output register; the
//   back end takes no new word while a divide runs; the divider holds the back end.
//   A 4-word queue lets the front keep taking words during a divide; busy
//   rises only when that queue is full.
// Reset
//   rst (synchronous, active high) empties the queue, drops every word in
//   flight and stops the divider. Data registers and the result word are not reset.
module complex_arith_unit import cau_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  req_type,
  input  logic signed [WORD_BITS-1:0] a_re,
  input  logic signed [WORD_BITS-1:0] a_im,
  input  logic signed [WORD_BITS-1:0] b_re,
  input  logic signed [WORD_BITS-1:0] b_im,
  output logic                        done,
  output logic signed [WORD_BITS-1:0] res_re,
  output logic signed [WORD_BITS-1:0] res_im,
  output logic                        div_zero,
  output logic                        saturated
);

  item_t   f_item;   // classified word from the front
  item_t   q_item;   // head of queue
  logic    push, pop, q_full, q_not_empty;
  result_t res;

  cau_front u_front (
    .start    (start),
    .busy     (busy),
    .req_type (req_type),
    .a_re     (a_re),
    .a_im     (a_im),
    .b_re     (b_re),
    .b_im     (b_im),
    .q_full   (q_full),
    .push     (push),
    .item     (f_item)
  );

  cau_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_item   (f_item),
    .pop       (pop),
    .rd_item   (q_item),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  cau_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_item      (q_item),
    .q_not_empty (q_not_empty),
    .pop         (pop),
    .done        (done),
    .res         (res)
  );

  assign res_re    = res.re;
  assign res_im    = res.im;
  assign div_zero  = res.dz;
  assign saturated = res.sat;

endmodule

FILE: test/tb.sv
// tb: self-checking bench for complex_arith_unit (add, subtract, multiply, divide).
// Depends on cau_pkg and the complex_arith_unit RTL. A queue-fed driver sends words in
// bursts, an exact predictor computes each result, and a monitor compares in order.
`timescale 1ns / 100ps

module tb import cau_pkg::*; ();

  typedef struct {
    logic [1:0]  op;
    logic [31:0] ar, ai, br, bi;
    bit          drain;   // hold off until every expected result has come
  } cplx_word_t;

  typedef struct {
    logic [31:0] re, im;
    logic        dz, sat;
  } cplx_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] req_type = OP_ADD;
  logic signed [31:0] a_re = '0, a_im = '0, b_re = '0, b_im = '0;
  logic done;
  logic signed [31:0] res_re, res_im;
  logic div_zero, saturated;

  cplx_word_t pending_words[$];
  cplx_res_t  expected_res[$];
  int  fail_count = 0;
  int  idle_cycles = 0;
  int  burst_left = 0;
  int  gap_left = 0;

  localparam int WATCHDOG_LIMIT = 5000;

  always #4 clk = ~clk;

  complex_arith_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
    .done(done), .res_re(res_re), .res_im(res_im),
    .div_zero(div_zero), .saturated(saturated)
  );

  // Clip an exact value to the signed 32-bit range; flag set when clipped.
  function automatic logic [31:0] clip32(input logic signed [127:0] v, inout logic flag);
    if (v > 128'sd2147483647) begin
      flag = 1'b1;
      return 32'h7fff_ffff;
    end
    if (v < -128'sd2147483648) begin
      flag = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // Divide rounded to nearest, ties away from zero, at 16 fraction bits.
  function automatic logic signed [127:0] div_round(input logic signed [127:0] num,
                                                    input logic [127:0] den);
    logic [127:0] mag;
    logic [127:0] q;
    mag = num[127] ? -num : num;
    q = ((mag << (FRAC_BITS + 1)) + den) / (den << 1);
    return num[127] ? -$signed(q) : $signed(q);
  endfunction

  function automatic cplx_res_t complex_result(input cplx_word_t w);
    logic signed [127:0] ar, ai, br, bi, re, im, rnd;
    logic [127:0] den;
    cplx_res_t r;
    ar = {{96{w.ar[31]}}, w.ar};
    ai = {{96{w.ai[31]}}, w.ai};
    br = {{96{w.br[31]}}, w.br};
    bi = {{96{w.bi[31]}}, w.bi};
    rnd = 128'sd1 <<< (FRAC_BITS - 1);
    r.dz = 1'b0;
    r.sat = 1'b0;
    case (w.op)
      OP_ADD: begin
        re = ar + br;
        im = ai + bi;
      end
      OP_SUB: begin
        re = ar - br;
        im = ai - bi;
      end
      OP_MUL: begin
        re = (ar * br - ai * bi + rnd) >>> FRAC_BITS;
        im = (ar * bi + ai * br + rnd) >>> FRAC_BITS;
      end
      default: begin
        if (br == 0 && bi == 0) begin
          r.dz = 1'b1;
          re = '0;
          im = '0;
        end else begin
          den = br * br + bi * bi;
          re = div_round(ar * br + ai * bi, den);
          im = div_round(ai * br - ar * bi, den);
        end
      end
    endcase
    r.re = clip32(re, r.sat);
    r.im = clip32(im, r.sat);
    return r;
  endfunction

  // Operand part of a random shape: full range, moderate, tiny, extreme or zero.
  function automatic logic [31:0] rand_part();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom();
      3, 4, 5: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      6:       return 32'($signed($urandom_range(0, 64)) - 32);
      7:       return ($urandom_range(0, 1)) ? 32'h7fff_ffff : 32'h8000_0000;
      8:       return 32'($signed($urandom_range(0, 1 << 27)) - (1 << 26));
      default: return '0;
    endcase
  endfunction

  task automatic queue_word(input logic [1:0] op, input logic [31:0] ar, ai, br, bi,
                            input bit drain = 1'b0);
    cplx_word_t w;
    w.op = op; w.ar = ar; w.ai = ai; w.br = br; w.bi = bi; w.drain = drain;
    pending_words.push_back(w);
  endtask

  // Driver: on accept, predict and pop; then choose burst, gap or drain hold-off.
  always @(posedge clk) begin
    cplx_word_t w;
    bit sent;
    sent = 1'b0;
    if (!rst) begin
      if (start && !busy) begin
        expected_res.push_back(complex_result(pending_words.pop_front()));
        sent = 1'b1;
      end
      if (start && busy) begin
        // word still waiting, keep it on the bus
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_words.size() == 0) begin
        start <= 1'b0;
      end else if (pending_words[0].drain && expected_res.size() != 0) begin
        start <= 1'b0;
      end else begin
        w = pending_words[0];
        req_type <= w.op;
        a_re <= w.ar;
        a_im <= w.ai;
        b_re <= w.br;
        b_im <= w.bi;
        start <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
    idle_cycles <= (sent || done) ? 0 : idle_cycles + 1;
  end

  // Monitor: results cannot be held off, so every done is checked in order.
  always @(posedge clk) begin
    cplx_res_t e;
    if (!rst && done) begin
      if (expected_res.size() == 0) begin
        $error("result with nothing expected: re=%h im=%h", res_re, res_im);
        fail_count++;
      end else begin
        e = expected_res.pop_front();
        if (res_re !== e.re) begin
          $error("res_re expected %h got %h", e.re, res_re);
          fail_count++;
        end
        if (res_im !== e.im) begin
          $error("res_im expected %h got %h", e.im, res_im);
          fail_count++;
        end
        if (div_zero !== e.dz) begin
          $error("div_zero expected %b got %b", e.dz, div_zero);
          fail_count++;
        end
        if (saturated !== e.sat) begin
          $error("saturated expected %b got %b", e.sat, saturated);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles with nothing accepted either side.
  always @(posedge clk) begin
    if (!rst && idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    // Directed: extremes, every operation, rounding ties, zero divisor, clipping.
    queue_word(OP_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    queue_word(OP_ADD, 32'h0001_0000, 32'hffff_0000, 32'h0002_8000, 32'h0000_0001);
    queue_word(OP_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    queue_word(OP_SUB, 32'hffff_ffff, 32'h0, 32'hffff_ffff, 32'h0000_0001);
    queue_word(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_word(OP_MUL, 32'h7fff_ffff, 32'h0, 32'h8000_0000, 32'h0);
    queue_word(OP_MUL, 32'h0000_0001, 32'h0, 32'h0000_8000, 32'h0);   // tie upward
    queue_word(OP_MUL, 32'hffff_ffff, 32'h0, 32'h0000_8000, 32'h0);   // negative tie
    queue_word(OP_MUL, 32'h0002_0000, 32'h0001_0000, 32'h0003_0000, 32'hffff_0000);
    queue_word(OP_DIV, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0);    // zero divisor
    queue_word(OP_DIV, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0);
    queue_word(OP_DIV, 32'h0, 32'h0, 32'h0001_0000, 32'h0);
    queue_word(OP_DIV, 32'h0000_0001, 32'h0, 32'h0002_0000, 32'h0);   // tie away
    queue_word(OP_DIV, 32'hffff_ffff, 32'h0, 32'h0002_0000, 32'h0);   // negative tie
    queue_word(OP_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'h0);
    queue_word(OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_word(OP_DIV, 32'h0003_0000, 32'h0004_0000, 32'h0001_0000, 32'hffff_0000);
    queue_word(OP_DIV, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    queue_word(OP_ADD, 32'h1234_5678, 32'h9abc_def0, 32'h0f0f_0f0f, 32'hf0f0_f0f0, 1'b1);
    // Random part; every few hundred words one waits for the pipe to empty.
    for (int i = 0; i < 1450; i++)
      queue_word(2'($urandom_range(0, 3)), rand_part(), rand_part(), rand_part(),
                 rand_part(), (i % 300) == 299);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (pending_words.size() != 0 || expected_res.size() != 0);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && expected_res.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

FILE: files.f
sv/cau_pkg.sv
sv/cau_front.sv
sv/cau_queue.sv
sv/cau_back.sv
sv/complex_arith_unit.sv
test/tb.sv
